// ----- sv/joystick_autofire_hid_encoder_top_defines.svh -----
// Assertion macros for the joystick encoder.
// Each macro takes a label, a condition and a consequence.
// The design must have a clk_i clock and an rst_ni reset in scope.
`ifndef JOYSTICK_AUTOFIRE_HID_ENCODER_TOP_DEFINES_SVH
`define JOYSTICK_AUTOFIRE_HID_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The consequence holds in the same cycle as the condition.
`define JAHE_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("jahe assertion failed");

// The consequence holds in the cycle after the condition.
`define JAHE_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("jahe assertion failed");

`else

`define JAHE_ASSERT_SAME(lbl, pre, post)
`define JAHE_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ----- sv/jahe_pkg.sv -----
package jahe_pkg;

  localparam int unsigned TickCounterBits = 16;
  localparam int unsigned CfgDataW        = 16;
  localparam int unsigned CfgAddrW        = 2;
  localparam int unsigned InDataW         = 24;
  localparam int unsigned OutDataW        = 24;

  typedef logic [TickCounterBits-1:0] tick_cnt_t;

  // register indices
  localparam logic [CfgAddrW-1:0] CfgRapidHalfPeriod = 2'd0;
  localparam logic [CfgAddrW-1:0] CfgSendPeriod      = 2'd1;

  localparam logic [CfgDataW-1:0] RapidHalfPeriodRst = 16'd40;
  localparam logic [CfgDataW-1:0] SendPeriodRst      = 16'd12;

  // hat codes
  localparam logic [3:0] HatUp        = 4'd0;
  localparam logic [3:0] HatUpRight   = 4'd1;
  localparam logic [3:0] HatRight     = 4'd2;
  localparam logic [3:0] HatDownRight = 4'd3;
  localparam logic [3:0] HatDown      = 4'd4;
  localparam logic [3:0] HatDownLeft  = 4'd5;
  localparam logic [3:0] HatLeft      = 4'd6;
  localparam logic [3:0] HatUpLeft    = 4'd7;
  localparam logic [3:0] HatNeutral   = 4'd8;

  typedef struct packed {
    logic [2:0] autofire;
    logic [2:0] fire;
    logic [3:0] dirs;
  } stick_t;

  // Active-low status: bits 0-3 directions, 4-6 fire after autofire gating.
  function automatic logic [6:0] status_bits(stick_t s, logic phase);
    logic [2:0] f;
    f = s.fire | (~s.autofire & {3{~phase}});
    return {f, s.dirs};
  endfunction

  // Diagonals win over single directions.
  function automatic logic [3:0] hat_from(logic [3:0] dirs_n);
    logic u, d, l, r;
    logic [3:0] hat;
    u = ~dirs_n[0];
    d = ~dirs_n[1];
    l = ~dirs_n[2];
    r = ~dirs_n[3];
    if (u && r)      hat = HatUpRight;
    else if (d && r) hat = HatDownRight;
    else if (d && l) hat = HatDownLeft;
    else if (u && l) hat = HatUpLeft;
    else if (u)      hat = HatUp;
    else if (r)      hat = HatRight;
    else if (d)      hat = HatDown;
    else if (l)      hat = HatLeft;
    else             hat = HatNeutral;
    return hat;
  endfunction

endpackage

// ----- sv/joystick_autofire_hid_encoder_top.sv -----
// Channel     | Dir | Handshake       | Payload
// s_axis      | in  | tvalid/tready   | one tick item: both sticks' sampled pins
// m_axis      | out | tvalid/tready   | status bytes and HID report
// cfg         | in  | cfg_we_i        | rapid_half_period (0), send_period (1)
//
// One item per cycle: an input register feeds a single pass of counter,
// gating and hat logic into the result register. An item that yields no
// result leaves the input register at once; one that yields a result waits
// only while the result register is full and stalled. Reset clears the
// counters, the phase and both valid flags and loads the period defaults.
`include "joystick_autofire_hid_encoder_top_defines.svh"

module joystick_autofire_hid_encoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // cfg
  input  logic                           cfg_we_i,
  input  logic [jahe_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [jahe_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input ticks
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // one_dirs[3:0], one_fire[6:4], one_autofire[9:7], two_dirs[13:10],
  // two_fire[16:14], two_autofire[19:17], zero pad [23:20]
  input  logic [jahe_pkg::InDataW-1:0]   s_axis_tdata_i,
  // results
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // first_byte[6:0], second_byte[14:7], hid_report[21:15], zero pad [23:22]
  output logic [jahe_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import jahe_pkg::*;

  // config registers
  logic [CfgDataW-1:0] rapid_half_q, send_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rapid_half_q  <= RapidHalfPeriodRst;
      send_period_q <= SendPeriodRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgRapidHalfPeriod: rapid_half_q  <= cfg_wdata_i;
        CfgSendPeriod:      send_period_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic   in_valid_q;
  stick_t one_q, two_q;
  logic   step;   // item in the input register is processed this cycle
  logic   emit;   // that item produces a result

  assign s_axis_tready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_valid_q <= 1'b0;
    else if (s_axis_tready_o) in_valid_q <= s_axis_tvalid_i;
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      one_q <= stick_t'(s_axis_tdata_i[9:0]);
      two_q <= stick_t'(s_axis_tdata_i[19:10]);
    end
  end

  // tick counters, saturating at all ones
  tick_cnt_t rapid_q, rapid_d, rapid_inc;
  tick_cnt_t send_q,  send_d,  send_inc;
  logic      phase_q, phase_d;
  logic      toggle;

  assign rapid_inc = (rapid_q == '1) ? rapid_q : rapid_q + tick_cnt_t'(1);
  assign send_inc  = (send_q == '1)  ? send_q  : send_q + tick_cnt_t'(1);
  assign toggle    = rapid_inc >= rapid_half_q;
  assign emit      = send_inc >= send_period_q;

  logic out_valid_q;
  assign step = in_valid_q && (!emit || !out_valid_q || m_axis_tready_i);

  always_comb begin
    rapid_d = rapid_q;
    send_d  = send_q;
    phase_d = phase_q;
    if (step) begin
      rapid_d = toggle ? '0 : rapid_inc;
      phase_d = phase_q ^ toggle;
      send_d  = emit ? '0 : send_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rapid_q <= '0;
      send_q  <= '0;
      phase_q <= 1'b0;
    end else begin
      rapid_q <= rapid_d;
      send_q  <= send_d;
      phase_q <= phase_d;
    end
  end

  // result payload, with the updated phase
  logic [6:0] st_one, st_two;
  logic [6:0] hid;
  assign st_one = status_bits(one_q, phase_d);
  assign st_two = status_bits(two_q, phase_d);
  assign hid    = {~st_one[6:4], hat_from(st_one[3:0])};

  logic [OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (step && emit) out_valid_q <= 1'b1;
    else if (m_axis_tready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) out_data_q <= {2'b00, hid, 1'b1, st_two, st_one};
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // a held item never vanishes without being processed
  `JAHE_ASSERT_NEXT(a_held_item_stays, in_valid_q && !step, in_valid_q)
  // an emitting item always lands in the result register
  `JAHE_ASSERT_NEXT(a_emit_fills_out, step && emit, out_valid_q && send_q == '0)
  // the player two marker bit is always set in a pending result
  `JAHE_ASSERT_SAME(a_second_marker, out_valid_q, out_data_q[14])

endmodule

// ----- sim/joystick_autofire_hid_encoder_top_test.sv -----
// Testbench for joystick_autofire_hid_encoder_top.
//
// Each input item is one millisecond tick with both sticks' pins. A local
// model of the tick counters, the autofire phase and the status/HID mapping
// predicts every report, and each report that leaves the block is compared
// field by field with the oldest prediction.
//
// Sequence: reset defaults, a hat and autofire sweep, writes to the unused
// register indices, then random phases with different period settings.
// The extremes 0 and all ones of both periods are among them.
module joystick_autofire_hid_encoder_top_test;
  import jahe_pkg::*;

  // Slowest correct run: ~1000 items, each with a random idle gap on the
  // sender, its pass through the block and a random stall on the receiver.
  // The limit is ten times the length of such a run.
  localparam int unsigned CycleLimit   = 200000;
  // Input and result registers: an item with no report may still be inside.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxGap       = 8;

  // Indices past the two registers; writes there must change nothing.
  localparam logic [CfgAddrW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgAddrW-1:0] CfgSpareB = 2'd3;

  localparam tick_cnt_t CountMax = '1;

  // One report as it sits in m_axis_tdata, first_byte lowest.
  typedef struct packed {
    logic [6:0] hid;
    logic [7:0] second;
    logic [6:0] first;
  } report_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CfgAddrW-1:0]  cfg_addr;
  logic [CfgDataW-1:0]  cfg_wdata;
  logic                 s_valid;
  logic                 s_ready;
  // one_dirs, one_fire, one_autofire, two_dirs, two_fire, two_autofire, pad
  logic [InDataW-1:0]   s_data;
  logic                 m_valid;
  logic                 m_ready;
  // first_byte, second_byte, hid_report, pad
  logic [OutDataW-1:0]  m_data;

  // Local copy of the block's registers and state.
  tick_cnt_t toggle_period;
  tick_cnt_t report_period;
  tick_cnt_t toggle_count;
  tick_cnt_t report_count;
  logic      fire_phase;

  report_t   pending_reports[$];
  int        mismatches;
  int        cycles;
  // Cleared for stretches in which neither side idles.
  bit        gaps_on;

  joystick_autofire_hid_encoder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Active-low status: a fire bit goes low when pressed and either its
  // autofire switch is off (high) or the phase is set.
  function automatic logic [6:0] stick_status(stick_t s, logic phase);
    logic [6:0] v;
    v = {3'b111, s.dirs};
    for (int i = 0; i < 3; i++) begin
      if (!s.fire[i] && (s.autofire[i] || phase)) v[4+i] = 1'b0;
    end
    return v;
  endfunction

  // Diagonals first, then up, right, down, left.
  function automatic logic [3:0] hat_code(logic [3:0] dirs_n);
    logic u, d, l, r;
    u = !dirs_n[0];
    d = !dirs_n[1];
    l = !dirs_n[2];
    r = !dirs_n[3];
    if (u && r) return HatUpRight;
    if (d && r) return HatDownRight;
    if (d && l) return HatDownLeft;
    if (u && l) return HatUpLeft;
    if (u)      return HatUp;
    if (r)      return HatRight;
    if (d)      return HatDown;
    if (l)      return HatLeft;
    return HatNeutral;
  endfunction

  // Advance the model by one tick; queue a report when the send count is due.
  task automatic count_tick(stick_t one, stick_t two);
    logic [6:0] s1;
    report_t    r;
    toggle_count = (toggle_count == CountMax) ? CountMax : toggle_count + 1'b1;
    report_count = (report_count == CountMax) ? CountMax : report_count + 1'b1;
    if (toggle_count >= toggle_period) begin
      fire_phase   = ~fire_phase;
      toggle_count = '0;
    end
    if (report_count >= report_period) begin
      report_count = '0;
      s1       = stick_status(one, fire_phase);
      r.first  = s1;
      r.second = {1'b1, stick_status(two, fire_phase)};
      r.hid    = {~s1[6:4], hat_code(s1[3:0])};
      pending_reports.push_back(r);
    end
  endtask

  // Offer one tick item after a random gap; valid stays high on return so
  // that back-to-back items need no second assignment in one step.
  task automatic send_tick(stick_t one, stick_t two);
    int gap;
    gap = gaps_on ? $urandom_range(0, MaxGap) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_data  <= {4'b0000, two, one};
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_ready);
    count_tick(one, two);
  endtask

  // Mostly random pins, now and then a stick left untouched.
  task automatic send_random_ticks(int n);
    stick_t one, two;
    for (int i = 0; i < n; i++) begin
      one = stick_t'(10'($urandom));
      two = stick_t'(10'($urandom));
      if ($urandom_range(0, 7) == 0) one = '1;
      if ($urandom_range(0, 7) == 0) two = '1;
      send_tick(one, two);
    end
  endtask

  // Block idle: valid dropped before the next edge, all reports in, then
  // room for a tick with no report.
  task automatic quiesce;
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    if (addr == CfgRapidHalfPeriod) toggle_period = value;
    else if (addr == CfgSendPeriod) report_period = value;
  endtask

  // Periods as left by reset: 12 ticks to the first report, phase still low.
  task automatic test_reset_defaults;
    for (int i = 0; i < 12; i++) begin
      if (i % 2 == 0) send_tick('1, '0);
      else            send_tick('0, '1);
    end
    quiesce();
  endtask

  // Both periods zero: a report per tick and a phase flip per tick, so the
  // sweep of all direction codes also sees autofire gated both ways.
  task automatic test_hat_sweep;
    stick_t one;
    write_reg(CfgRapidHalfPeriod, '0);
    write_reg(CfgSendPeriod, '0);
    for (int i = 0; i < 16; i++) begin
      one.dirs     = 4'(i);
      one.fire     = 3'(i >> 1);
      one.autofire = 3'(i >> 2);
      send_tick(one, ~one);
    end
    quiesce();
  endtask

  task automatic test_register_index;
    write_reg(CfgSpareA, '1);
    write_reg(CfgSpareB, 16'h0005);
    send_random_ticks(3);
    quiesce();
  endtask

  // Random items under a range of period settings, extremes included.
  task automatic test_random_phases;
    tick_cnt_t rapid, send;
    int        n;
    for (int p = 0; p < 7; p++) begin
      n = 150;
      case (p)
        0: begin rapid = '0;     send = '0; end
        1: begin rapid = 16'd1;  send = 16'd1; end
        2: begin rapid = '1;     send = tick_cnt_t'($urandom_range(0, 6)); end
        3: begin
          rapid = tick_cnt_t'($urandom_range(2, 50));
          send  = tick_cnt_t'($urandom_range(2, 10));
        end
        // no report can fall due here; the count carries into the next phase
        4: begin rapid = RapidHalfPeriodRst; send = '1; n = 40; end
        5: begin
          rapid = tick_cnt_t'($urandom_range(0, 65535));
          send  = tick_cnt_t'($urandom_range(0, 4));
        end
        default: begin
          rapid = tick_cnt_t'($urandom_range(1, 8));
          send  = tick_cnt_t'($urandom_range(0, 3));
        end
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      write_reg(CfgRapidHalfPeriod, rapid);
      write_reg(CfgSendPeriod, send);
      send_random_ticks(n);
      quiesce();
    end
    gaps_on = 1'b1;
  endtask

  // Receiver: stall for a random gap, then take one report.
  initial begin : report_sink
    int stall;
    m_ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      stall = gaps_on ? $urandom_range(0, MaxGap) : 0;
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_valid && m_ready));
    end
  end

  always @(posedge clk_i) begin : check_reports
    report_t got, want;
    if (rst_ni && m_valid && m_ready) begin
      got = m_data[21:0];
      if (pending_reports.size() == 0) begin
        mismatches++;
        $display("%0t: report with none expected, expected none, actual %h", $time, got);
      end else begin
        want = pending_reports.pop_front();
        if (got.first !== want.first) begin
          mismatches++;
          $display("%0t: first_byte expected %h actual %h", $time, want.first, got.first);
        end
        if (got.second !== want.second) begin
          mismatches++;
          $display("%0t: second_byte expected %h actual %h", $time, want.second, got.second);
        end
        if (got.hid !== want.hid) begin
          mismatches++;
          $display("%0t: hid_report expected %h actual %h", $time, want.hid, got.hid);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_wdata     = '0;
    s_valid       = 1'b0;
    s_data        = '0;
    mismatches    = 0;
    cycles        = 0;
    gaps_on       = 1'b1;
    toggle_period = RapidHalfPeriodRst;
    report_period = SendPeriodRst;
    toggle_count  = '0;
    report_count  = '0;
    fire_phase    = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_hat_sweep();
    test_register_index();
    test_random_phases();

    quiesce();
    repeat (2 * SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
